// ===== hw/rtl/src_pkg.sv =====
// Shared types and constants for the stripe refresh controller.
package src_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_BASE_QUALITY   = 3'd0;
  localparam logic [2:0] REG_REFINE_QUALITY = 3'd1;
  localparam logic [2:0] REG_REFINE_ENABLE  = 3'd2;
  localparam logic [2:0] REG_STILL_TRIGGER  = 3'd3;
  localparam logic [2:0] REG_DAMAGE_LIMIT   = 3'd4;
  localparam logic [2:0] REG_BLOCK_LENGTH   = 3'd5;

  // Configuration reset values
  localparam logic [6:0] BASE_QUALITY_RST   = 7'd85;
  localparam logic [6:0] REFINE_QUALITY_RST = 7'd95;
  localparam logic       REFINE_ENABLE_RST  = 1'b0;
  localparam logic [7:0] STILL_TRIGGER_RST  = 8'd10;
  localparam logic [7:0] DAMAGE_LIMIT_RST   = 8'd15;
  localparam logic [7:0] BLOCK_LENGTH_RST   = 8'd30;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  // Per-stripe state word held in the stripe memory
  typedef struct packed {
    logic [63:0] last_hash;
    logic [7:0]  still_count;
    logic        refine_sent;
    logic [7:0]  damage_count;
    logic        blocked;
    logic [7:0]  block_timer;
    logic [6:0]  stripe_quality;
  } entry_t;

  // Value of an entry never written since reset (start quality from reset registers)
  localparam entry_t ENTRY_RST = '{
    last_hash:      64'd0,
    still_count:    8'd0,
    refine_sent:    1'b0,
    damage_count:   8'd0,
    blocked:        1'b0,
    block_timer:    8'd0,
    stripe_quality: BASE_QUALITY_RST
  };

endpackage

// ===== hw/rtl/stripe_refresh_controller_core.sv =====
// Stripe refresh controller: per-stripe encode decision with one state memory.
//
// Input beats (in_valid/in_stall) carry a stripe index and the stripe's 64-bit
// content hash. Each input beat yields exactly one result beat
// (out_valid/out_stall): encode_now, encode_quality and is_refine.
// Configuration writes use cfg_valid/cfg_ready with a register index and data;
// cfg_ready is always high. Write configuration only while the block is idle.
//
// A beat's synchronous read of the stripe memory loads with the update stage,
// then the update's result lands in the output register. Throughput is one
// beat per cycle while out_stall does not hold the output register; the single
// read-modify-write port pair of the stripe memory sets that figure, and a
// forwarding register covers the same stripe arriving on consecutive beats.
// While out_stall holds a full output register, the update stage holds and
// in_stall rises once the update stage is also occupied. Reset clears all valid
// bits, so every stripe reads as its reset state, and restores the configuration
// registers; no clearing pass runs.
// An index at or above N_STRIPES returns an all-zero result and changes nothing.
module stripe_refresh_controller_core #(
  parameter int N_STRIPES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_stripe_index,
  input  logic [63:0] in_content_hash,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_encode_now,
  output logic [6:0]  out_encode_quality,
  output logic        out_is_refine,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW = (N_STRIPES > 1) ? $clog2(N_STRIPES) : 1;
  localparam logic [8:0] IDX_LIMIT = 9'(N_STRIPES);

  // Configuration registers
  logic [6:0] base_quality_r;
  logic [6:0] refine_quality_r;
  logic       refine_enable_r;
  logic [7:0] still_trigger_r;
  logic [7:0] damage_limit_r;
  logic [7:0] block_length_r;

  // Stripe memory and valid bits
  src_pkg::entry_t   mem [N_STRIPES];
  logic [N_STRIPES-1:0] entry_valid_r;
  src_pkg::entry_t   rd_data_r;
  logic              rd_valid_r;

  // Update stage
  logic          s1_valid_r;
  logic [AW-1:0] s1_addr_r;
  logic [63:0]   s1_hash_r;
  logic          s1_in_range_r;

  // Last write, for forwarding
  logic            fwd_valid_r;
  logic [AW-1:0]   fwd_addr_r;
  src_pkg::entry_t fwd_data_r;

  // Output register
  logic       out_valid_r;
  logic       out_encode_now_r;
  logic [6:0] out_encode_quality_r;
  logic       out_is_refine_r;

  logic            in_accept;
  logic            s1_adv;
  logic            wr_en;
  logic [8:0]      in_idx_ext;
  logic [AW-1:0]   in_addr;
  logic            in_in_range;
  src_pkg::entry_t cur;
  src_pkg::entry_t upd;
  logic            enc;
  logic [6:0]      enc_q;
  logic            enc_refine;
  logic [6:0]      dec_q;
  logic [6:0]      step_q;

  assign cfg_ready = 1'b1;

  // Advance the update stage when the output register is free or draining
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign wr_en     = s1_valid_r && s1_adv && s1_in_range_r;

  assign in_idx_ext  = {5'd0, in_stripe_index};
  assign in_addr     = in_idx_ext[AW-1:0];
  assign in_in_range = in_idx_ext < IDX_LIMIT;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_quality_r   <= src_pkg::BASE_QUALITY_RST;
      refine_quality_r <= src_pkg::REFINE_QUALITY_RST;
      refine_enable_r  <= src_pkg::REFINE_ENABLE_RST;
      still_trigger_r  <= src_pkg::STILL_TRIGGER_RST;
      damage_limit_r   <= src_pkg::DAMAGE_LIMIT_RST;
      block_length_r   <= src_pkg::BLOCK_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        src_pkg::REG_BASE_QUALITY:   base_quality_r   <= cfg_data[6:0];
        src_pkg::REG_REFINE_QUALITY: refine_quality_r <= cfg_data[6:0];
        src_pkg::REG_REFINE_ENABLE:  refine_enable_r  <= cfg_data[0];
        src_pkg::REG_STILL_TRIGGER:  still_trigger_r  <= cfg_data;
        src_pkg::REG_DAMAGE_LIMIT:   damage_limit_r   <= cfg_data;
        src_pkg::REG_BLOCK_LENGTH:   block_length_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Read the stripe memory on accept, write back from the update stage
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data_r <= mem[in_addr];
    end
    if (wr_en) begin
      mem[s1_addr_r] <= upd;
    end
  end

  // Track written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      rd_valid_r    <= 1'b0;
    end else begin
      if (in_accept) begin
        rd_valid_r <= in_in_range && entry_valid_r[in_addr];
      end
      if (wr_en) begin
        entry_valid_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  // Advance the update stage; an empty stage loads even behind a stalled result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv || !s1_valid_r) begin
      s1_valid_r <= in_accept;
    end
    if (in_accept) begin
      s1_addr_r     <= in_addr;
      s1_hash_r     <= in_content_hash;
      s1_in_range_r <= in_in_range;
    end
  end

  // Hold the last write for the next beat's read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (wr_en) begin
      fwd_valid_r <= 1'b1;
    end
    if (wr_en) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= upd;
    end
  end

  // Pick current entry: forwarded write, stored word, or reset state
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr_r)) begin
      cur = fwd_data_r;
    end else if (rd_valid_r) begin
      cur = rd_data_r;
    end else begin
      cur = src_pkg::ENTRY_RST;
    end
  end

  // Decide and update the entry
  always_comb begin
    upd        = cur;
    enc        = 1'b0;
    enc_q      = 7'd0;
    enc_refine = 1'b0;
    dec_q      = (cur.stripe_quality != 7'd0) ? (cur.stripe_quality - 7'd1) : 7'd0;
    step_q     = (dec_q > base_quality_r) ? dec_q : base_quality_r;

    if (s1_hash_r == cur.last_hash) begin
      if (cur.still_count != src_pkg::COUNT_MAX) begin
        upd.still_count = cur.still_count + 8'd1;
      end
      if ((upd.still_count >= still_trigger_r) && refine_enable_r &&
          !cur.refine_sent && !cur.blocked) begin
        enc             = 1'b1;
        enc_q           = refine_quality_r;
        enc_refine      = 1'b1;
        upd.refine_sent = 1'b1;
      end
    end else begin
      upd.still_count    = 8'd0;
      upd.refine_sent    = 1'b0;
      upd.stripe_quality = step_q;
      upd.last_hash      = s1_hash_r;
      enc                = 1'b1;
      enc_q              = step_q;
      if (cur.damage_count != src_pkg::COUNT_MAX) begin
        upd.damage_count = cur.damage_count + 8'd1;
      end
      if (upd.damage_count >= damage_limit_r) begin
        upd.blocked     = 1'b1;
        upd.block_timer = block_length_r;
      end
    end

    // Count down the block timer after the decision
    if (upd.block_timer != 8'd0) begin
      upd.block_timer = upd.block_timer - 8'd1;
      if (upd.block_timer == 8'd0) begin
        upd.blocked        = 1'b0;
        upd.damage_count   = 8'd0;
        upd.stripe_quality = refine_enable_r ? refine_quality_r : base_quality_r;
      end
    end

    if (!s1_in_range_r) begin
      enc        = 1'b0;
      enc_q      = 7'd0;
      enc_refine = 1'b0;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_adv && s1_valid_r) begin
      out_encode_now_r     <= enc;
      out_encode_quality_r <= enc_q;
      out_is_refine_r      <= enc_refine;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_encode_now     = out_encode_now_r;
  assign out_encode_quality = out_encode_quality_r;
  assign out_is_refine      = out_is_refine_r;

endmodule

// ===== hw/rtl/src_checker.sv =====
// Port-level checks for the stripe refresh controller, bound to the top level.
module src_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_encode_now,
  input logic [6:0] out_encode_quality,
  input logic       out_is_refine
);

  // Drop the result channel during reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // Hold a stalled result beat
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_encode_now) &&
      $stable(out_encode_quality) && $stable(out_is_refine))
    else $error("stalled result beat changed");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

  // No encode means zero quality and no paint-over
  a_no_encode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_encode_now |-> out_encode_quality == 7'd0 && !out_is_refine)
    else $error("fields set without encode");

  // Paint-over is always an encode
  a_refine_enc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_refine |-> out_encode_now)
    else $error("paint-over without encode");

endmodule

bind stripe_refresh_controller_core src_checker u_src_checker (.*);
